// File: hdl/mra_pkg.sv
// ----------------------------------------------------------------------------
// mra_pkg
// Shared types and constants of the message ring allocator.
// ----------------------------------------------------------------------------
package mra_pkg;

  localparam int RING_MAX   = 4096;
  localparam int DESC_DEPTH = 16;

  // ring offsets and lengths run 0..RING_MAX inclusive
  localparam int IDX_W   = $clog2(RING_MAX) + 1;
  localparam int LEN_W   = 13;
  localparam int START_W = 12;
  localparam int CFG_W   = 13;
  localparam int PTR_W   = $clog2(DESC_DEPTH);
  localparam int CNT_W   = $clog2(DESC_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_LENERR  = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_DROPPED = 3'd4
  } status_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_t;

  // one queued message: start offset and length
  typedef struct packed {
    logic [IDX_W-1:0] start;
    logic [LEN_W-1:0] len;
  } desc_t;

  // controller -> descriptor queue
  typedef struct packed {
    logic  push;
    logic  pop;
    desc_t wr_desc;
  } fifo_cmd_t;

  // descriptor queue -> controller
  typedef struct packed {
    logic  empty;
    logic  full;
    desc_t rd_desc;
  } fifo_stat_t;

  // one result transfer
  typedef struct packed {
    status_t            status;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } res_t;

endpackage

// File: hdl/message_ring_allocator.sv
// ----------------------------------------------------------------------------
// message_ring_allocator
// Contiguous space allocator for variable-length messages in a byte ring.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive in_req_type / in_msg_len and pulse start. A request
//   transfers at a rising edge with start high and busy low. in_req_type 0
//   reserves in_msg_len bytes, 1 pops the oldest stored message descriptor.
//   Result channel: out_valid is high for exactly one cycle per request with
//   out_status, out_start_index and out_len. There is no back-pressure; the
//   receiver must take every result in the cycle it is shown.
//   Config channel: cfg_data (ring size in bytes) transfers on cfg_valid &&
//   cfg_ready; sizes above the memory size are clipped. Write only while no
//   request is in flight.
// Timing:
//   A request passes the request register, then one pass of compare and
//   subtract logic on the index registers into the result register.
//   With busy low, throughput is one request per cycle; the state update of
//   one request is complete at the edge where the next request is evaluated.
// Reset:
//   rst_n is synchronous, active low. It clears indices, pages and the
//   descriptor count and sets the size to 2048. busy is high during reset and
//   until a clock edge samples rst_n high; descriptor storage is not cleared.
// ----------------------------------------------------------------------------
module message_ring_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  // request
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [mra_pkg::LEN_W-1:0]     in_msg_len,
  // result
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [mra_pkg::START_W-1:0]   out_start_index,
  output logic [mra_pkg::LEN_W-1:0]     out_len,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mra_pkg::CFG_W-1:0]     cfg_data
);
  import mra_pkg::*;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(2048);

  logic               busy_r;
  logic [IDX_W-1:0]   size_r, size_nxt;

  // request register
  logic               req_vld_r;
  req_t               req_type_r;
  logic [LEN_W-1:0]   req_len_r;

  // result register
  logic               res_vld_r;
  res_t               res_r;

  res_t               res;
  fifo_cmd_t          fifo_cmd;
  fifo_stat_t         fifo_stat;
  logic               accept;

  assign busy      = busy_r;
  assign cfg_ready = ~busy_r;
  assign accept    = start & ~busy_r;

  // clip the size once on the write, not in the request path
  assign size_nxt = (cfg_data > CFG_W'(RING_MAX)) ? IDX_W'(RING_MAX) : IDX_W'(cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      size_r    <= IDX_W'(SIZE_RESET);
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      busy_r    <= 1'b0;
      req_vld_r <= accept;
      res_vld_r <= req_vld_r;
      if (cfg_valid && cfg_ready) begin
        size_r <= size_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= req_t'(in_req_type);
      req_len_r  <= in_msg_len;
    end
    if (req_vld_r) begin
      res_r <= res;
    end
  end

  mra_ring_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_vld   (req_vld_r),
    .req_type  (req_type_r),
    .req_len   (req_len_r),
    .ring_size (size_r),
    .fifo_stat (fifo_stat),
    .fifo_cmd  (fifo_cmd),
    .res       (res)
  );

  mra_desc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (fifo_cmd),
    .stat  (fifo_stat)
  );

  assign out_valid       = res_vld_r;
  assign out_status      = res_r.status;
  assign out_start_index = res_r.start;
  assign out_len         = res_r.len;

endmodule

// File: hdl/mra_desc_fifo.sv
// ----------------------------------------------------------------------------
// mra_desc_fifo
// Descriptor queue: register file with head/tail pointers and a fill count.
// ----------------------------------------------------------------------------
module mra_desc_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  mra_pkg::fifo_cmd_t cmd,
  output mra_pkg::fifo_stat_t stat
);
  import mra_pkg::*;

  desc_t             desc_mem_r [DESC_DEPTH];
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DESC_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // entries are only read while count is nonzero
  assign stat.empty   = (count_r == '0);
  assign stat.full    = (count_r == CNT_W'(DESC_DEPTH));
  assign stat.rd_desc = desc_mem_r[head_r];

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.push && !stat.full) begin
      tail_nxt  = ptr_inc(tail_r);
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop && !stat.empty) begin
      head_nxt  = ptr_inc(head_r);
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !stat.full) begin
      desc_mem_r[tail_r] <= cmd.wr_desc;
    end
  end

endmodule

// File: hdl/mra_ring_ctrl.sv
// ----------------------------------------------------------------------------
// mra_ring_ctrl
// Ring index/page state and the per-request allocate / release decision.
// ----------------------------------------------------------------------------
module mra_ring_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req_vld,
  input  mra_pkg::req_t               req_type,
  input  logic [mra_pkg::LEN_W-1:0]   req_len,
  input  logic [mra_pkg::IDX_W-1:0]   ring_size,
  input  mra_pkg::fifo_stat_t         fifo_stat,
  output mra_pkg::fifo_cmd_t          fifo_cmd,
  output mra_pkg::res_t               res
);
  import mra_pkg::*;

  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             wr_pg_r, wr_pg_nxt;
  logic             rd_pg_r, rd_pg_nxt;

  always_comb begin
    logic             idx_eq;
    logic             pg_eq;
    logic             grant;
    logic             wrap;
    logic [IDX_W-1:0] room;
    logic [IDX_W-1:0] start;
    logic [IDX_W:0]   rd_end;
    desc_t            d;

    idx_eq = (wr_idx_r == rd_idx_r);
    pg_eq  = (wr_pg_r == rd_pg_r);
    grant  = 1'b0;
    wrap   = 1'b0;
    room   = '0;
    start  = '0;
    d      = fifo_stat.rd_desc;
    rd_end = {1'b0, d.start} + {1'b0, d.len};

    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    wr_pg_nxt  = wr_pg_r;
    rd_pg_nxt  = rd_pg_r;
    fifo_cmd   = '0;
    res        = '{status: ST_OK, start: '0, len: '0};

    if (req_vld && req_type == REQ_WRITE) begin
      res.status = ST_FULL;
      if (idx_eq && pg_eq && wr_idx_r == '0) begin
        // empty ring
        if (req_len > ring_size) begin
          res.status = ST_LENERR;
        end else begin
          grant = 1'b1;
        end
      end else if (!pg_eq) begin
        // writer one lap ahead: free space lies up to the read index
        room = (rd_idx_r >= wr_idx_r) ? rd_idx_r - wr_idx_r : '0;
        if (!idx_eq && room >= req_len) begin
          grant = 1'b1;
          start = wr_idx_r;
        end
      end else begin
        room = (ring_size >= wr_idx_r) ? ring_size - wr_idx_r : '0;
        if (room >= req_len) begin
          grant = 1'b1;
          start = wr_idx_r;
        end else if (rd_idx_r >= req_len) begin
          grant = 1'b1;
          wrap  = 1'b1;
        end
      end

      if (grant) begin
        wr_idx_nxt       = start + req_len;
        wr_pg_nxt        = wr_pg_r ^ wrap;
        fifo_cmd.push    = 1'b1;
        fifo_cmd.wr_desc = '{start: start, len: req_len};
        res.status       = fifo_stat.full ? ST_DROPPED : ST_OK;
        res.start        = start[START_W-1:0];
        res.len          = req_len;
      end
    end else if (req_vld) begin
      if (fifo_stat.empty) begin
        res.status = ST_EMPTY;
      end else begin
        fifo_cmd.pop = 1'b1;
        res.start    = d.start[START_W-1:0];
        res.len      = d.len;
        if (rd_end > {1'b0, ring_size}) begin
          res.status = ST_LENERR;
        end else begin
          res.status = ST_OK;
          rd_idx_nxt = rd_end[IDX_W-1:0];
          // message behind the read index means the reader wrapped
          rd_pg_nxt  = rd_pg_r ^ (d.start < rd_idx_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      wr_pg_r  <= 1'b0;
      rd_pg_r  <= 1'b0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      wr_pg_r  <= wr_pg_nxt;
      rd_pg_r  <= rd_pg_nxt;
    end
  end

endmodule

// File: hdl/mra_checker.sv
// ----------------------------------------------------------------------------
// mra_checker
// Port-level timing and result checks, bound to the top level.
// ----------------------------------------------------------------------------
module mra_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [2:0]                    out_status,
  input logic [mra_pkg::START_W-1:0]   out_start_index,
  input logic [mra_pkg::LEN_W-1:0]     out_len
);
  import mra_pkg::*;

  // every accepted request yields a result through the request and result registers
  a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted request produced no result");

  // no result without an accepted request that passed the request and result registers
  a_res_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result strobe without request");

  // refused writes and empty reads carry no placement
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL || out_status == ST_EMPTY))
      |-> (out_start_index == '0 && out_len == '0))
    else $error("refused request carries nonzero start or length");

  // reset kills any result in flight
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind message_ring_allocator mra_checker u_mra_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_start_index (out_start_index),
  .out_len         (out_len)
);

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the message ring allocator. A directed plan walks
// the corner cases of the ring (empty, full, wrap, exact fit, dropped
// descriptors, bad sizes), then random reserve/read traffic runs over a set
// of ring sizes. Every result transfer is checked against a local model of
// the ring indices, pages and descriptor queue.
// ----------------------------------------------------------------------------
module testbench;
  import mra_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 99;
  localparam int NUM_PHASES      = 9;
  localparam int DRAIN_LIMIT     = 1000;
  localparam int REPORT_LIMIT    = 10;

  // kinds of rows in the directed plan
  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_READ,
    ROW_SIZE
  } row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [LEN_W-1:0]   val;     // msg_len, or ring size for ROW_SIZE
    int                 reps;
    bit                 chk;     // typed-in expectation below is valid
    status_t            st;
    logic [START_W-1:0] s;
    logic [LEN_W-1:0]   l;
  } plan_row_t;

  localparam int PLAN_ROWS = 30;

  // Directed plan. Starts at the reset size of 2048.
  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_READ,     0, 1, 1, ST_EMPTY,   0,    0},  // nothing stored yet
    '{ROW_WRITE, 4096, 1, 1, ST_LENERR,  0,    0},  // largest length, empty ring
    '{ROW_WRITE, 2049, 1, 1, ST_LENERR,  0,    0},  // one over the size
    '{ROW_WRITE, 2048, 1, 1, ST_OK,      0, 2048},  // exact fit
    '{ROW_WRITE,    1, 1, 1, ST_FULL,    0,    0},  // no tail room, no head room
    '{ROW_WRITE,    0, 1, 1, ST_OK,   2048,    0},  // zero length at the very end
    '{ROW_READ,     0, 1, 1, ST_OK,      0, 2048},
    '{ROW_READ,     0, 1, 1, ST_OK,   2048,    0},
    '{ROW_WRITE,  100, 1, 0, ST_OK,      0,    0},  // wraps to 0, page toggles
    '{ROW_WRITE,  100, 1, 0, ST_OK,      0,    0},  // pages differ, room up to read
    '{ROW_WRITE, 1849, 1, 1, ST_FULL,    0,    0},  // one byte short
    '{ROW_WRITE, 1848, 1, 0, ST_OK,      0,    0},  // closes the gap exactly
    '{ROW_WRITE,    0, 1, 1, ST_FULL,    0,    0},  // indices equal, pages differ
    '{ROW_READ,     0, 3, 0, ST_OK,      0,    0},  // first read toggles read page
    '{ROW_READ,     0, 1, 1, ST_EMPTY,   0,    0},
    '{ROW_SIZE,  8191, 1, 0, ST_OK,      0,    0},  // above memory size, clipped
    '{ROW_WRITE, 2048, 1, 0, ST_OK,      0,    0},
    '{ROW_WRITE,    0, 1, 1, ST_OK,      0,    0},  // offset 4096 shows as 0
    '{ROW_SIZE,  1024, 1, 0, ST_OK,      0,    0},  // shrink under stored data
    '{ROW_READ,     0, 1, 1, ST_LENERR, 2048, 2048},
    '{ROW_READ,     0, 1, 1, ST_LENERR,  0,    0},
    '{ROW_SIZE,     0, 1, 0, ST_OK,      0,    0},  // ring with no room
    '{ROW_WRITE,    1, 1, 0, ST_OK,      0,    0},
    '{ROW_WRITE,    0, 1, 0, ST_OK,      0,    0},
    '{ROW_READ,     0, 2, 0, ST_OK,      0,    0},
    '{ROW_SIZE,  4096, 1, 0, ST_OK,      0,    0},
    '{ROW_WRITE,    0, 16, 0, ST_OK,     0,    0},  // fills the descriptor queue
    '{ROW_WRITE,    0, 1, 1, ST_DROPPED, 1,    0},  // space taken, descriptor lost
    '{ROW_READ,     0, 16, 0, ST_OK,     0,    0},
    '{ROW_READ,     0, 1, 1, ST_EMPTY,   0,    0}
  };

  // DUT ports
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_req_type = 1'b0;
  logic [LEN_W-1:0]   in_msg_len = '0;
  logic               out_valid;
  logic [2:0]         out_status;
  logic [START_W-1:0] out_start_index;
  logic [LEN_W-1:0]   out_len;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data = '0;

  // Local copy of the ring: size register, indices, pages, descriptor queue
  logic [CFG_W-1:0]   ring_size_q = 13'd2048;
  logic [IDX_W-1:0]   wr_idx = '0;
  logic [IDX_W-1:0]   rd_idx = '0;
  logic               wr_pg = 1'b0;
  logic               rd_pg = 1'b0;
  desc_t              stored_msgs [$];

  // results owed by the DUT, oldest first
  res_t               due_results [$];
  res_t               want;

  int                 cycle_count = 0;
  int                 fail_count = 0;
  int                 stat_seen [5] = '{0, 0, 0, 0, 0};
  int                 n_writes = 0;
  int                 n_reads = 0;
  int                 n_sizes = 0;

  message_ring_allocator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_msg_len      (in_msg_len),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_start_index (out_start_index),
    .out_len         (out_len),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Size the ring actually uses: anything above the memory is clipped.
  function automatic int live_size();
    return (int'(ring_size_q) > RING_MAX) ? RING_MAX : int'(ring_size_q);
  endfunction

  // Outcome of one request on the local ring; updates the local state.
  function automatic res_t ring_outcome(req_t req, logic [LEN_W-1:0] len);
    res_t  r;
    int    sz;
    int    wi;
    int    ri;
    int    room;
    int    at;
    bit    wrap;
    desc_t d;
    sz   = live_size();
    wi   = int'(wr_idx);
    ri   = int'(rd_idx);
    wrap = 1'b0;
    at   = 0;
    r    = '{status: ST_OK, start: '0, len: '0};
    if (req == REQ_WRITE) begin
      if (wi == ri && wr_pg == rd_pg && wi == 0) begin
        // empty ring: the message always lands at 0 if it fits at all
        if (int'(len) > sz) begin
          r.status = ST_LENERR;
          return r;
        end
      end else if (wi == ri && wr_pg != rd_pg) begin
        r.status = ST_FULL;
        return r;
      end else if (wr_pg != rd_pg) begin
        // writer has wrapped: free space sits between write and read index
        room = (ri >= wi) ? ri - wi : 0;
        if (room < int'(len)) begin
          r.status = ST_FULL;
          return r;
        end
        at = wi;
      end else begin
        // same page: try the tail, then wrap to the head
        room = (sz >= wi) ? sz - wi : 0;
        if (room >= int'(len)) begin
          at = wi;
        end else if (ri >= int'(len)) begin
          wrap = 1'b1;
        end else begin
          r.status = ST_FULL;
          return r;
        end
      end
      wr_idx = IDX_W'(at + int'(len));
      if (wrap) wr_pg = ~wr_pg;
      if (stored_msgs.size() < DESC_DEPTH) begin
        d.start = IDX_W'(at);
        d.len   = len;
        stored_msgs.push_back(d);
      end else begin
        r.status = ST_DROPPED;
      end
      r.start = START_W'(at);
      r.len   = len;
    end else begin
      if (stored_msgs.size() == 0) begin
        r.status = ST_EMPTY;
        return r;
      end
      d       = stored_msgs.pop_front();
      r.start = d.start[START_W-1:0];
      r.len   = d.len;
      if (int'(d.start) + int'(d.len) > sz) begin
        // descriptor no longer fits the ring: discard, indices untouched
        r.status = ST_LENERR;
        return r;
      end
      if (d.start < rd_idx) rd_pg = ~rd_pg;
      rd_idx = IDX_W'(int'(d.start) + int'(d.len));
    end
    return r;
  endfunction

  task automatic note_failure(string what);
    if (fail_count < REPORT_LIMIT) $display("[%0d] ERROR %s", cycle_count, what);
    fail_count++;
  endtask

  // Lengths biased toward the interesting spots: zero, the largest value,
  // an exact fit of the ring, and mostly pieces small enough to force wraps.
  function automatic logic [LEN_W-1:0] pick_len();
    int sz;
    int r;
    sz = live_size();
    r  = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 14) return LEN_W'(RING_MAX);
    if (r < 20) return LEN_W'($urandom_range(0, RING_MAX));
    if (r < 28) return LEN_W'(sz);
    return LEN_W'($urandom_range(0, (sz / 3 > 0) ? sz / 3 : 1));
  endfunction

  // One request transfer. The sender may idle first; start stays high from
  // the previous transfer when it does not, so back-to-back requests keep
  // a steady start.
  task automatic send_request(req_t req, logic [LEN_W-1:0] len, int idle_pct,
                              output res_t predicted);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_msg_len  <= len;
    do @(posedge clk); while (busy);
    predicted = ring_outcome(req, len);
    due_results.push_back(predicted);
    if (req == REQ_WRITE) n_writes++;
    else n_reads++;
  endtask

  // Drop start and wait for every owed result; anything that never comes
  // counts as a failure so the run can move on.
  task automatic settle();
    start <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && due_results.size() != 0; n++) @(posedge clk);
    if (due_results.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", due_results.size()));
      fail_count += due_results.size() - 1;
      due_results.delete();
    end
  endtask

  task automatic set_ring_size(logic [CFG_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    ring_size_q = v;
    n_sizes++;
  endtask

  // Result checker: the receiver cannot stall, so each strobe is taken as is.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      if (out_status < 3'd5) stat_seen[out_status]++;
      if (due_results.size() == 0) begin
        note_failure($sformatf("unexpected result status=%0d start=%0d len=%0d",
                               out_status, out_start_index, out_len));
      end else begin
        want = due_results.pop_front();
        if (out_status !== want.status || out_start_index !== want.start ||
            out_len !== want.len) begin
          note_failure($sformatf("result mismatch: want status=%0d start=%0d len=%0d, got status=%0d start=%0d len=%0d",
                                 want.status, want.start, want.len,
                                 out_status, out_start_index, out_len));
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    res_t got;
    int   base_pct;
    int   pct;
    int   write_pct;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed plan. Typed-in expectations cross-check the local model on
    // the easy rows; the DUT itself is always checked against the model.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SIZE) begin
        set_ring_size(plan[i].val);
      end else begin
        for (int k = 0; k < plan[i].reps; k++) begin
          send_request((plan[i].kind == ROW_WRITE) ? REQ_WRITE : REQ_READ,
                       plan[i].val, 0, got);
          if (plan[i].chk && (got.status != plan[i].st || got.start != plan[i].s ||
                              got.len != plan[i].l)) begin
            note_failure($sformatf("plan row %0d: want status=%0d start=%0d len=%0d, model gives %0d/%0d/%0d",
                                   i, plan[i].st, plan[i].s, plan[i].l,
                                   got.status, got.start, got.len));
          end
        end
      end
    end

    // Random traffic, one ring size per phase. Sender idles up to 36% in the
    // first third, 47% in the second, never in the last; every 20 transfers
    // the write/read mix is redrawn so the queue both fills up and runs dry.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_ring_size(13'd2048);
        1: set_ring_size(13'd1);
        2: set_ring_size(13'd4096);
        3: set_ring_size(13'd8191);
        4: set_ring_size(13'd0);
        5: set_ring_size(13'd16);
        6: set_ring_size(CFG_W'($urandom_range(1, RING_MAX)));
        7: set_ring_size(CFG_W'($urandom_range(0, 8191)));
        default: set_ring_size(13'd300);
      endcase
      base_pct = (ph < 3) ? 36 : (ph < 6) ? 47 : 0;
      pct = base_pct;
      write_pct = 50;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 20 == 0) begin
          write_pct = $urandom_range(25, 85);
          pct = ($urandom_range(0, 3) == 0) ? 0 : base_pct;
        end
        if ($urandom_range(0, 99) < write_pct)
          send_request(REQ_WRITE, pick_len(), pct, got);
        else
          send_request(REQ_READ, LEN_W'($urandom_range(0, RING_MAX)), pct, got);
      end
    end

    settle();
    repeat (4) @(posedge clk);

    $display("Ran %0d reserve and %0d read transfers over %0d ring size settings.",
             n_writes, n_reads, n_sizes);
    $display("Results seen: ok %0d, full %0d, length error %0d, empty %0d, dropped %0d.",
             stat_seen[0], stat_seen[1], stat_seen[2], stat_seen[3], stat_seen[4]);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
